/* design/vrt_pkg.sv */
// shared types, widths and helpers for the vertex rotate/translate core
// no dependencies; imported by vrt_cell, vertex_rotate_translate_core and the bench
`timescale 1ns / 1ps
`default_nettype none

package vrt_pkg;

  // internal coordinate width, holds any value reached between axis steps
  localparam int CW = 26;
  // product and sum widths inside a rotation cell
  localparam int PW = CW + 16;
  localparam int SW = PW + 1;
  localparam int FRAC_SHIFT = 14;

  localparam logic signed [SW-1:0] ROUND_HALF = SW'(8192);
  localparam logic signed [CW-1:0] SAT_MAX = CW'(32767);
  localparam logic signed [CW-1:0] SAT_MIN = CW'(-32768);

  localparam logic [31:0] ROT_RESET = 32'h4000_0000;

  // configuration register indexes
  localparam logic [1:0] REG_ROT_X = 2'd0;
  localparam logic [1:0] REG_ROT_Y = 2'd1;
  localparam logic [1:0] REG_ROT_Z = 2'd2;
  localparam logic [1:0] REG_TRANS = 2'd3;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
    logic [31:0]        vertex_color;
    logic               frame_end;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic [31:0]        out_color;
    logic               out_frame_end;
  } out_word_t;

  // word moving down the cell chain: (a, b) is the pair the next cell
  // rotates, w the untouched axis; pivots travel with their coordinates
  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] w;
    logic signed [15:0]   pa;
    logic signed [15:0]   pb;
    logic signed [15:0]   pw;
    logic [31:0]          color;
    logic                 frame_end;
  } vrt_item_t;

  function automatic logic signed [CW-1:0] sext16(input logic signed [15:0] v);
    logic signed [CW-1:0] r;
    r = {{(CW-16){v[15]}}, v};
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [CW-1:0] v);
    logic signed [15:0] r;
    if (v > SAT_MAX) begin
      r = 16'sh7fff;
    end else if (v < SAT_MIN) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/vrt_cell.sv */
// one axis rotation cell: rotates (a, b) about (pa, pb) with a cos/sin pair
// output word is cyclically reordered so identical cells chain x, y, z axes
// depends on vrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module vrt_cell
  import vrt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic       in_vld,
  input  wire vrt_item_t  in_item,
  input  wire logic [31:0] cos_sin,
  output logic            out_vld,
  output vrt_item_t       out_item
);

  logic signed [15:0]   c;
  logic signed [15:0]   s;
  logic signed [CW-1:0] ra;
  logic signed [CW-1:0] rb;

  logic signed [PW-1:0] p_ac_r, p_ac_nxt;
  logic signed [PW-1:0] p_bs_r, p_bs_nxt;
  logic signed [PW-1:0] p_as_r, p_as_nxt;
  logic signed [PW-1:0] p_bc_r, p_bc_nxt;
  logic                 mul_vld_r;
  vrt_item_t            mul_item_r;

  logic signed [SW-1:0] t_a, t_b;
  logic signed [SW-1:0] sh_a, sh_b;
  vrt_item_t            out_item_r, out_item_nxt;
  logic                 out_vld_r;

  // stage one: relative coordinates and the four products
  always_comb begin
    c = $signed(cos_sin[31:16]);
    s = $signed(cos_sin[15:0]);
    ra = in_item.a - sext16(in_item.pa);
    rb = in_item.b - sext16(in_item.pb);
    p_ac_nxt = PW'(ra) * PW'(c);
    p_bs_nxt = PW'(rb) * PW'(s);
    p_as_nxt = PW'(ra) * PW'(s);
    p_bc_nxt = PW'(rb) * PW'(c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else if (en) begin
      mul_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ac_r     <= p_ac_nxt;
      p_bs_r     <= p_bs_nxt;
      p_as_r     <= p_as_nxt;
      p_bc_r     <= p_bc_nxt;
      mul_item_r <= in_item;
    end
  end

  // stage two: sum, round half up and drop 14 fraction bits, add the pivot back
  always_comb begin
    t_a = SW'(p_ac_r) - SW'(p_bs_r);
    t_b = SW'(p_as_r) + SW'(p_bc_r);
    sh_a = (t_a + ROUND_HALF) >>> FRAC_SHIFT;
    sh_b = (t_b + ROUND_HALF) >>> FRAC_SHIFT;
    // reorder (a, b, w) -> (b', w, a')
    out_item_nxt.a = sext16(mul_item_r.pb) + $signed(sh_b[CW-1:0]);
    out_item_nxt.b = mul_item_r.w;
    out_item_nxt.w = sext16(mul_item_r.pa) + $signed(sh_a[CW-1:0]);
    out_item_nxt.pa = mul_item_r.pb;
    out_item_nxt.pb = mul_item_r.pw;
    out_item_nxt.pw = mul_item_r.pa;
    out_item_nxt.color = mul_item_r.color;
    out_item_nxt.frame_end = mul_item_r.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_item = out_item_r;

endmodule

`default_nettype wire

/* design/vertex_rotate_translate_core.sv */
// an accepted word passes three rotation cells of two register stages each, then the
// output register, before it shows on out_valid
// throughput: one word per cycle while out_ready is high; the chain stalls as a whole
// reset (rst_n, synchronous, active low) empties the chain, zeroes the pivot and
// loads identity rotations (cos 1, sin 0) and a zero translation
`timescale 1ns / 1ps
`default_nettype none

module vertex_rotate_translate_core
  import vrt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_wdata
);

  logic [31:0] rot_x_r, rot_y_r, rot_z_r;
  logic [47:0] trans_r;

  logic signed [15:0] pivot_x_r, pivot_x_nxt;
  logic signed [15:0] pivot_y_r, pivot_y_nxt;
  logic signed [15:0] pivot_z_r, pivot_z_nxt;
  logic signed [15:0] tx, ty, tz;

  logic      adv;
  logic      in_acc;
  vrt_item_t c0_item;
  logic      c1_vld, c2_vld, c3_vld;
  vrt_item_t c1_item, c2_item, c3_item;

  logic      out_valid_r;
  out_word_t out_data_r, out_data_nxt;
  logic [3:0] pipe_vld;

  // whole chain moves whenever the output register can take a word
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign in_acc   = in_valid && adv;

  assign tx = $signed(trans_r[47:32]);
  assign ty = $signed(trans_r[31:16]);
  assign tz = $signed(trans_r[15:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_x_r <= ROT_RESET;
      rot_y_r <= ROT_RESET;
      rot_z_r <= ROT_RESET;
      trans_r <= 48'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROT_X: rot_x_r <= cfg_wdata[31:0];
        REG_ROT_Y: rot_y_r <= cfg_wdata[31:0];
        REG_ROT_Z: rot_z_r <= cfg_wdata[31:0];
        REG_TRANS: trans_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pivot advances after the frame's last word; that word keeps the old one
  always_comb begin
    pivot_x_nxt = pivot_x_r;
    pivot_y_nxt = pivot_y_r;
    pivot_z_nxt = pivot_z_r;
    if (in_acc && in_data.frame_end) begin
      pivot_x_nxt = sat16(sext16(pivot_x_r) + sext16(tx));
      pivot_y_nxt = sat16(sext16(pivot_y_r) + sext16(ty));
      pivot_z_nxt = sat16(sext16(pivot_z_r) + sext16(tz));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_x_r <= 16'sd0;
      pivot_y_r <= 16'sd0;
      pivot_z_r <= 16'sd0;
    end else begin
      pivot_x_r <= pivot_x_nxt;
      pivot_y_r <= pivot_y_nxt;
      pivot_z_r <= pivot_z_nxt;
    end
  end

  // x axis rotates (y, z) first, so the chain starts in (y, z, x) order
  always_comb begin
    c0_item.a = sext16(in_data.vertex_y);
    c0_item.b = sext16(in_data.vertex_z);
    c0_item.w = sext16(in_data.vertex_x);
    c0_item.pa = pivot_y_r;
    c0_item.pb = pivot_z_r;
    c0_item.pw = pivot_x_r;
    c0_item.color = in_data.vertex_color;
    c0_item.frame_end = in_data.frame_end;
  end

  vrt_cell u_cell_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (in_valid),
    .in_item  (c0_item),
    .cos_sin  (rot_x_r),
    .out_vld  (c1_vld),
    .out_item (c1_item)
  );

  vrt_cell u_cell_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (c1_vld),
    .in_item  (c1_item),
    .cos_sin  (rot_y_r),
    .out_vld  (c2_vld),
    .out_item (c2_item)
  );

  vrt_cell u_cell_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (c2_vld),
    .in_item  (c2_item),
    .cos_sin  (rot_z_r),
    .out_vld  (c3_vld),
    .out_item (c3_item)
  );

  // after three cells the order is back to (y, z, x)
  always_comb begin
    out_data_nxt.out_x = sat16(c3_item.w + sext16(tx));
    out_data_nxt.out_y = sat16(c3_item.a + sext16(ty));
    out_data_nxt.out_z = sat16(c3_item.b + sext16(tz));
    out_data_nxt.out_color = c3_item.color;
    out_data_nxt.out_frame_end = c3_item.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pipe_vld  = {c1_vld, c2_vld, c3_vld, out_valid_r};

  a_pivot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && in_data.frame_end) |=>
      $stable(pivot_x_r) && $stable(pivot_y_r) && $stable(pivot_z_r))
    else $error("pivot moved without a frame end word");

  a_chain_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(pipe_vld))
    else $error("cell chain advanced during a stall");

  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !c3_vld |=> !out_valid_r)
    else $error("output word repeated after it was taken");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with an empty output register");

endmodule

`default_nettype wire

/* bench/tb_vertex_rotate_translate_core.sv */
// self-checking bench for vertex_rotate_translate_core: directed rows, then random words
// under several idle patterns, checked by given results or an in-bench transform model
// depends on vrt_pkg and the core RTL
`timescale 1ns / 1ps

module tb_vertex_rotate_translate_core;
  import vrt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int WORDS_PER_PHASE = 106;
  localparam int TAIL_CYCLES = 20;
  localparam longint HALF_LSB = 64'sd1 <<< (FRAC_SHIFT - 1);

  // one line of the directed table: either a register write or a vertex
  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [47:0] reg_val;
    in_word_t    vtx;
    bit          typed;
    out_word_t   want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_wdata;

  // bench copy of the register file and the pivot
  logic [31:0]        rot_x_cs = ROT_RESET;
  logic [31:0]        rot_y_cs = ROT_RESET;
  logic [31:0]        rot_z_cs = ROT_RESET;
  logic [47:0]        trans_xyz = '0;
  logic signed [15:0] piv_x = '0;
  logic signed [15:0] piv_y = '0;
  logic signed [15:0] piv_z = '0;

  out_word_t transformed_q[$];
  dir_row_t  dir_rows[$];
  int        gap_pct = 0;
  int        stall_pct = 0;
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;

  vertex_rotate_translate_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // a' = pa + round(ra*c - rb*s), b' = pb + round(ra*s + rb*c); ties round up
  function automatic void turn_pair(inout longint a, inout longint b, input longint pa,
                                    input longint pb, input logic [31:0] cs);
    longint c, s, ra, rb;
    c = $signed(cs[31:16]);
    s = $signed(cs[15:0]);
    ra = a - pa;
    rb = b - pb;
    a = pa + ((ra * c - rb * s + HALF_LSB) >>> FRAC_SHIFT);
    b = pb + ((ra * s + rb * c + HALF_LSB) >>> FRAC_SHIFT);
  endfunction

  function automatic out_word_t transform_vertex(input in_word_t v);
    out_word_t r;
    longint x, y, z, tx, ty, tz, px, py, pz;
    x = $signed(v.vertex_x);
    y = $signed(v.vertex_y);
    z = $signed(v.vertex_z);
    tx = $signed(trans_xyz[47:32]);
    ty = $signed(trans_xyz[31:16]);
    tz = $signed(trans_xyz[15:0]);
    px = piv_x;
    py = piv_y;
    pz = piv_z;
    // x axis, then y (z,x pair), then z
    turn_pair(y, z, py, pz, rot_x_cs);
    turn_pair(z, x, pz, px, rot_y_cs);
    turn_pair(x, y, px, py, rot_z_cs);
    r.out_x = clamp16(x + tx);
    r.out_y = clamp16(y + ty);
    r.out_z = clamp16(z + tz);
    r.out_color = v.vertex_color;
    r.out_frame_end = v.frame_end;
    // the frame's last vertex still used the old pivot
    if (v.frame_end) begin
      piv_x = clamp16(px + tx);
      piv_y = clamp16(py + ty);
      piv_z = clamp16(pz + tz);
    end
    return r;
  endfunction

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(2))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_coord();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return 16'($urandom_range(32767) - 16384);
    if (sel < 9) return 16'($urandom);
    return pick_extreme();
  endfunction

  function automatic logic [31:0] pick_rotation();
    real ang;
    logic [15:0] c, s;
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) begin
      ang = $urandom_range(35999) * 3.14159265358979 / 18000.0;
      c = 16'(int'($cos(ang) * 16384.0));
      s = 16'(int'($sin(ang) * 16384.0));
      return {c, s};
    end
    if (sel < 7) return ROT_RESET;
    if (sel == 7) return {pick_extreme(), pick_extreme()};
    return $urandom;
  endfunction

  function automatic logic [47:0] pick_translation();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) begin
      return {16'($urandom_range(4095) - 2048), 16'($urandom_range(4095) - 2048),
              16'($urandom_range(4095) - 2048)};
    end
    if (sel < 8) return {16'($urandom), $urandom};
    return {pick_extreme(), pick_extreme(), pick_extreme()};
  endfunction

  function automatic in_word_t pick_vertex();
    in_word_t w;
    w.vertex_x = pick_coord();
    w.vertex_y = pick_coord();
    w.vertex_z = pick_coord();
    w.vertex_color = $urandom;
    w.frame_end = ($urandom_range(7) == 0);
    return w;
  endfunction

  function automatic void row_cfg(input logic [1:0] idx, input logic [47:0] val);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_vtx(input logic [15:0] x, input logic [15:0] y,
                                  input logic [15:0] z, input logic [31:0] color,
                                  input logic fe);
    dir_row_t r;
    r = '{default: '0};
    r.vtx = '{x, y, z, color, fe};
    dir_rows.push_back(r);
  endfunction

  // vertex row whose result is obvious by eye
  function automatic void row_chk(input logic [15:0] x, input logic [15:0] y,
                                  input logic [15:0] z, input logic [31:0] color,
                                  input logic fe, input logic [15:0] ex,
                                  input logic [15:0] ey, input logic [15:0] ez);
    dir_row_t r;
    r = '{default: '0};
    r.vtx = '{x, y, z, color, fe};
    r.typed = 1'b1;
    r.want = '{ex, ey, ez, color, fe};
    dir_rows.push_back(r);
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      void'(transform_vertex(w));
      transformed_q.push_back(want);
    end else begin
      transformed_q.push_back(transform_vertex(w));
    end
  endtask

  // registers only change with the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (transformed_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_ROT_X: rot_x_cs = val[31:0];
      REG_ROT_Y: rot_y_cs = val[31:0];
      REG_ROT_Z: rot_z_cs = val[31:0];
      REG_TRANS: trans_xyz = val;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (transformed_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected word: x=%h y=%h z=%h color=%h fe=%b", out_data.out_x,
                   out_data.out_y, out_data.out_z, out_data.out_color,
                   out_data.out_frame_end);
        end
      end else begin
        out_word_t want;
        want = transformed_q.pop_front();
        if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
            out_data.out_z !== want.out_z || out_data.out_color !== want.out_color ||
            out_data.out_frame_end !== want.out_frame_end) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: want x=%h y=%h z=%h color=%h fe=%b", want.out_x,
                     want.out_y, want.out_z, want.out_color, want.out_frame_end);
            $display("          got  x=%h y=%h z=%h color=%h fe=%b", out_data.out_x,
                     out_data.out_y, out_data.out_z, out_data.out_color,
                     out_data.out_frame_end);
          end
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t  row;
    out_word_t none;
    int        mode;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_ROT_X;
    cfg_wdata <= '0;
    none = '0;

    // identity rotations, zero translation and pivot after reset
    row_chk(16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0,
            16'h0000, 16'h0000, 16'h0000);
    row_chk(16'h7fff, 16'h7fff, 16'h7fff, 32'hffff_ffff, 1'b0,
            16'h7fff, 16'h7fff, 16'h7fff);
    row_chk(16'h8000, 16'h8000, 16'h8000, 32'h0000_0000, 1'b1,
            16'h8000, 16'h8000, 16'h8000);
    row_chk(16'h1234, 16'hedcc, 16'h00ff, 32'ha5a5_a5a5, 1'b0,
            16'h1234, 16'hedcc, 16'h00ff);
    // full positive translation: saturation high, pivot moves to the top at frame end
    row_cfg(REG_TRANS, 48'h7fff_7fff_7fff);
    row_chk(16'h7fff, 16'h7fff, 16'h7fff, 32'h5a5a_5a5a, 1'b0,
            16'h7fff, 16'h7fff, 16'h7fff);
    row_chk(16'h0000, 16'h0000, 16'h0000, 32'h0000_0001, 1'b0,
            16'h7fff, 16'h7fff, 16'h7fff);
    row_chk(16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 1'b1,
            16'hffff, 16'hffff, 16'hffff);
    // full negative translation: saturation low, pivot walks down to the floor
    row_cfg(REG_TRANS, 48'h8000_8000_8000);
    row_chk(16'h8000, 16'h8000, 16'h8000, 32'h0f0f_0f0f, 1'b0,
            16'h8000, 16'h8000, 16'h8000);
    row_chk(16'h7fff, 16'h7fff, 16'h7fff, 32'hf0f0_f0f0, 1'b1,
            16'hffff, 16'hffff, 16'hffff);
    row_chk(16'h0000, 16'h0000, 16'h0000, 32'h1357_9bdf, 1'b1,
            16'h8000, 16'h8000, 16'h8000);
    row_chk(16'h0100, 16'h0200, 16'h0300, 32'h2468_ace0, 1'b1,
            16'h8100, 16'h8200, 16'h8300);
    // quarter turn about x, non-unit extreme pairs on y and z, far pivot
    row_cfg(REG_ROT_X, 48'h0000_4000);
    row_cfg(REG_ROT_Y, 48'h7fff_8000);
    row_cfg(REG_ROT_Z, 48'h8000_7fff);
    row_cfg(REG_TRANS, 48'h0100_ff00_0080);
    row_vtx(16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
    row_vtx(16'h7fff, 16'h8000, 16'h7fff, 32'hffff_ffff, 1'b0);
    row_vtx(16'h8000, 16'h7fff, 16'h8000, 32'h1111_1111, 1'b1);
    row_vtx(16'h1000, 16'h2000, 16'h3000, 32'h2222_2222, 1'b0);
    row_cfg(REG_ROT_X, 48'hffff_ffff);
    row_cfg(REG_ROT_Y, 48'h8000_8000);
    row_cfg(REG_ROT_Z, 48'h7fff_7fff);
    row_cfg(REG_TRANS, 48'h0000_0000_0000);
    row_vtx(16'h7fff, 16'h7fff, 16'h7fff, 32'h3333_3333, 1'b0);
    row_vtx(16'h8000, 16'h8000, 16'h8000, 32'h4444_4444, 1'b0);
    row_vtx(16'hffff, 16'h0001, 16'h8001, 32'h5555_5555, 1'b1);
    // 22.5 deg on x, -45 deg on y, -90 deg on z, small translation
    row_cfg(REG_ROT_X, 48'h3b21_187e);
    row_cfg(REG_ROT_Y, 48'h2d41_d2bf);
    row_cfg(REG_ROT_Z, 48'h0000_c000);
    row_cfg(REG_TRANS, 48'h0080_ff80_0040);
    row_vtx(16'h0100, 16'h0000, 16'h0000, 32'h6666_6666, 1'b0);
    row_vtx(16'h0000, 16'h0100, 16'h0000, 32'h7777_7777, 1'b0);
    row_vtx(16'h0000, 16'h0000, 16'h0100, 32'h8888_8888, 1'b1);
    row_vtx(16'hc000, 16'h4000, 16'hc000, 32'h9999_9999, 1'b0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        settle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        cfg_we <= 1'b0;
        send_word(row.vtx, row.typed, row.want);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      gap_pct = 0;
      stall_pct = 0;
      write_reg(REG_ROT_X, {16'h0, pick_rotation()});
      write_reg(REG_ROT_Y, {16'h0, pick_rotation()});
      write_reg(REG_ROT_Z, {16'h0, pick_rotation()});
      write_reg(REG_TRANS, pick_translation());
      cfg_we <= 1'b0;
      mode = p % 4;
      case (mode)
        1: gap_pct = 87;
        2: stall_pct = 87;
        3: begin
          gap_pct = 34;
          stall_pct = 34;
        end
        default: ;
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_word(pick_vertex(), 1'b0, none);
      end
    end

    settle();
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
